FILE: rtl/oqwd_pkg.sv
// Shared types and codes for the ordered queue with delete.
`timescale 1ns / 1ps

package oqwd_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountOutW = 5;

  // Request type codes.
  localparam logic [1:0] ReqAppend = 2'd0;
  localparam logic [1:0] ReqRemove = 2'd1;
  localparam logic [1:0] ReqPop    = 2'd2;

  // Result status codes.
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [ValueW-1:0] req_value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] popped_value;
    logic [CountOutW-1:0]     entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_POP,
    OP_REMOVE_START,
    OP_SCAN_STEP,
    OP_IGNORE,
    OP_RESPOND
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       empty;
    logic       scan_last;
  } dp_status_t;

endpackage

FILE: rtl/oqwd_datapath.sv
// Datapath: entry cells, fill count, request latch, result and output registers.
`timescale 1ns / 1ps

module oqwd_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oqwd_pkg::req_t      in_data_i,
  input  oqwd_pkg::dp_cmd_t   cmd_i,
  output oqwd_pkg::dp_status_t status_o,
  output oqwd_pkg::rsp_t      out_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic signed [oqwd_pkg::ValueW-1:0] cells_q [DEPTH];
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         scan_cnt_q, scan_cnt_d;
  logic                  found_q, found_d;
  oqwd_pkg::req_t        req_q;
  logic [1:0]            st_q;
  logic signed [oqwd_pkg::ValueW-1:0] popped_q;
  oqwd_pkg::rsp_t        out_data_q;

  logic                  full, empty, drop;
  logic                  shift_en, rotate_en;
  logic [CW-1:0]         count_m1;
  logic [IW-1:0]         tail_idx;
  logic signed [oqwd_pkg::ValueW-1:0] head;

  assign head     = cells_q[0];
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - 1'b1;
  assign tail_idx = count_m1[IW-1:0];
  // During the scan the head leaves the ring only on the first match.
  assign drop     = (cmd_i.op == oqwd_pkg::OP_SCAN_STEP) && !found_q &&
                    (head == req_q.req_value);
  assign shift_en  = (cmd_i.op == oqwd_pkg::OP_POP && !empty) ||
                     (cmd_i.op == oqwd_pkg::OP_SCAN_STEP);
  assign rotate_en = (cmd_i.op == oqwd_pkg::OP_SCAN_STEP) && !drop;

  always_comb begin
    count_d    = count_q;
    scan_cnt_d = scan_cnt_q;
    found_d    = found_q;
    case (cmd_i.op)
      oqwd_pkg::OP_APPEND: if (!full) count_d = count_q + 1'b1;
      oqwd_pkg::OP_POP:    if (!empty) count_d = count_m1;
      oqwd_pkg::OP_REMOVE_START: begin
        scan_cnt_d = count_q;
        found_d    = 1'b0;
      end
      oqwd_pkg::OP_SCAN_STEP: begin
        scan_cnt_d = scan_cnt_q - 1'b1;
        if (drop) begin
          count_d = count_m1;
          found_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_cnt_q <= '0;
      found_q    <= 1'b0;
    end else begin
      count_q    <= count_d;
      scan_cnt_q <= scan_cnt_d;
      found_q    <= found_d;
    end
  end

  // Cell chain: every cell but the last can load its younger neighbor, and the tail cell can
  // take back the head so that a full scan restores the original order.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == oqwd_pkg::OP_APPEND && !full) begin
      cells_q[count_q[IW-1:0]] <= req_q.req_value;
    end else if (shift_en) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        cells_q[i] <= (rotate_en && tail_idx == IW'(i)) ? head : cells_q[i+1];
      end
      if (rotate_en && tail_idx == IW'(DEPTH - 1)) begin
        cells_q[DEPTH-1] <= head;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      oqwd_pkg::OP_LOAD: req_q <= in_data_i;
      oqwd_pkg::OP_APPEND: begin
        st_q     <= full ? oqwd_pkg::StFull : oqwd_pkg::StDone;
        popped_q <= '0;
      end
      oqwd_pkg::OP_POP: begin
        st_q     <= empty ? oqwd_pkg::StEmpty : oqwd_pkg::StDone;
        popped_q <= empty ? '0 : head;
      end
      oqwd_pkg::OP_REMOVE_START: begin
        st_q     <= oqwd_pkg::StNotFound;
        popped_q <= '0;
      end
      oqwd_pkg::OP_SCAN_STEP: if (drop) st_q <= oqwd_pkg::StDone;
      oqwd_pkg::OP_IGNORE: begin
        st_q     <= oqwd_pkg::StDone;
        popped_q <= '0;
      end
      oqwd_pkg::OP_RESPOND: begin
        out_data_q.status       <= st_q;
        out_data_q.popped_value <= popped_q;
        out_data_q.entry_count  <= oqwd_pkg::CountOutW'(count_q);
      end
      default: ;
    endcase
  end

  assign status_o.req_type  = req_q.req_type;
  assign status_o.empty     = empty;
  assign status_o.scan_last = (scan_cnt_q == CW'(1));
  assign out_data_o         = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == oqwd_pkg::OP_APPEND && !full) |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the queue");

  a_scan_single_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == oqwd_pkg::OP_SCAN_STEP && found_q) |=> count_q == $past(count_q))
    else $error("scan removed more than one entry");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == oqwd_pkg::OP_SCAN_STEP) |-> (scan_cnt_q != '0))
    else $error("scan step with no entries left to visit");

endmodule

FILE: rtl/oqwd_ctrl.sv
// Controller: request sequencing and the output handshake.
`timescale 1ns / 1ps

module oqwd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  oqwd_pkg::dp_status_t status_i,
  output oqwd_pkg::dp_cmd_t    cmd_o
);

  oqwd_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oqwd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = oqwd_pkg::OP_NONE;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      oqwd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = oqwd_pkg::OP_LOAD;
          state_d  = oqwd_pkg::ST_EXEC;
        end
      end
      oqwd_pkg::ST_EXEC: begin
        state_d = oqwd_pkg::ST_RESP;
        case (status_i.req_type)
          oqwd_pkg::ReqAppend: cmd_o.op = oqwd_pkg::OP_APPEND;
          oqwd_pkg::ReqPop:    cmd_o.op = oqwd_pkg::OP_POP;
          oqwd_pkg::ReqRemove: begin
            cmd_o.op = oqwd_pkg::OP_REMOVE_START;
            if (!status_i.empty) state_d = oqwd_pkg::ST_SCAN;
          end
          default: cmd_o.op = oqwd_pkg::OP_IGNORE;
        endcase
      end
      oqwd_pkg::ST_SCAN: begin
        cmd_o.op = oqwd_pkg::OP_SCAN_STEP;
        if (status_i.scan_last) state_d = oqwd_pkg::ST_RESP;
      end
      oqwd_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = oqwd_pkg::OP_RESPOND;
          out_valid_d = 1'b1;
          state_d     = oqwd_pkg::ST_IDLE;
        end
      end
      default: state_d = oqwd_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> (cmd_o.op != oqwd_pkg::OP_RESPOND))
    else $error("result overwritten while stalled");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == oqwd_pkg::OP_LOAD) |=> (state_q == oqwd_pkg::ST_EXEC))
    else $error("request load did not start execution");

endmodule

FILE: rtl/ordered_queue_with_delete.sv
// Top level of the ordered queue with delete.
`timescale 1ns / 1ps

// Insertion-ordered queue of signed 32-bit values in DEPTH entry cells. One
// request is taken at a time: append, pop and ignored request types pass
// through accept, execute and respond steps to a loaded result register; a
// remove adds one scan step per entry of the fill count before respond, because
// the entries rotate one per cycle past a single comparator at the head cell and
// the full rotation puts the survivors back in order. A waiting result does not
// stop the next request from being accepted; only the respond step waits for the
// output register to free up.
module ordered_queue_with_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  oqwd_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output oqwd_pkg::rsp_t out_data_o
);

  oqwd_pkg::dp_cmd_t    cmd;
  oqwd_pkg::dp_status_t status;

  oqwd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  oqwd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
